### rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge of clk, masked while rst is high
`define YBD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every rising edge of clk, reset included
`define YBD_ASSERT_NR(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/yenc_pkg.sv
package yenc_pkg;

  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] CHAR_LF  = 8'h0a;
  localparam logic [7:0] CHAR_DOT = 8'h2e;
  localparam logic [7:0] CHAR_EQ  = 8'h3d;
  localparam logic [7:0] CHAR_Y   = 8'h79;

  localparam logic [7:0] DATA_OFFSET   = 8'd42;
  localparam logic [7:0] ESCAPE_OFFSET = 8'd64;

  localparam logic [2:0] BEGIN_LEN = 3'd7;
  localparam logic [2:0] END_LEN   = 3'd5;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       kind;
    logic       last;
  } result_t;

  // up to two results from one article byte, first slot filled first
  typedef struct packed {
    logic    first_valid;
    result_t first;
    logic    second_valid;
    result_t second;
  } push_t;

  function automatic logic [7:0] plain_decode(input logic [7:0] b);
    plain_decode = b - DATA_OFFSET;
  endfunction

  function automatic logic [7:0] escaped_decode(input logic [7:0] b);
    escaped_decode = b - ESCAPE_OFFSET - DATA_OFFSET;
  endfunction

  // characters of =ybegin by position
  function automatic logic [7:0] begin_char(input logic [2:0] pos);
    case (pos)
      3'd0: begin_char = 8'h3d;
      3'd1: begin_char = 8'h79;
      3'd2: begin_char = 8'h62;
      3'd3: begin_char = 8'h65;
      3'd4: begin_char = 8'h67;
      3'd5: begin_char = 8'h69;
      3'd6: begin_char = 8'h6e;
      default: begin_char = 8'h00;
    endcase
  endfunction

  // characters of =yend by position
  function automatic logic [7:0] end_char(input logic [2:0] pos);
    case (pos)
      3'd0: end_char = 8'h3d;
      3'd1: end_char = 8'h79;
      3'd2: end_char = 8'h65;
      3'd3: end_char = 8'h6e;
      3'd4: end_char = 8'h64;
      default: end_char = 8'h00;
    endcase
  endfunction

endpackage

### rtl/yenc_core.sv
module yenc_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [7:0]         byte_in,
  output yenc_pkg::push_t    push
);

  logic       in_body, in_body_next;
  logic       at_line_start, at_line_start_next;
  logic       escape_pending, escape_pending_next;
  logic       dot_pending, dot_pending_next;
  logic       leading_eq_pending, leading_eq_pending_next;
  logic       skip_rest_of_line, skip_rest_of_line_next;
  logic [2:0] marker_match_pos, marker_match_pos_next;
  logic       marker_alive, marker_alive_next;

  logic       e0_valid;
  logic [7:0] e0_byte;
  logic       e1_valid;
  logic [7:0] e1_byte;
  logic       e1_kind;
  logic       dot_consumed;

  always_comb begin
    in_body_next            = in_body;
    at_line_start_next      = at_line_start;
    escape_pending_next     = escape_pending;
    dot_pending_next        = dot_pending;
    leading_eq_pending_next = leading_eq_pending;
    skip_rest_of_line_next  = skip_rest_of_line;
    marker_match_pos_next   = marker_match_pos;
    marker_alive_next       = marker_alive;
    e0_valid     = 1'b0;
    e0_byte      = '0;
    e1_valid     = 1'b0;
    e1_byte      = '0;
    e1_kind      = yenc_pkg::KIND_DATA;
    dot_consumed = 1'b0;

    if (byte_in == yenc_pkg::CHAR_CR) begin
      // carriage return leaves everything as it is
    end else if (byte_in == yenc_pkg::CHAR_LF) begin
      if (in_body && dot_pending) begin
        e1_valid = 1'b1;
        e1_byte  = yenc_pkg::plain_decode(yenc_pkg::CHAR_DOT);
      end
      at_line_start_next      = 1'b1;
      escape_pending_next     = 1'b0;
      dot_pending_next        = 1'b0;
      leading_eq_pending_next = 1'b0;
      skip_rest_of_line_next  = 1'b0;
      marker_match_pos_next   = '0;
      marker_alive_next       = 1'b1;
    end else if (!in_body) begin
      at_line_start_next = 1'b0;
      if (!skip_rest_of_line) begin
        if (marker_alive && (marker_match_pos < yenc_pkg::BEGIN_LEN) &&
            (byte_in == yenc_pkg::begin_char(marker_match_pos))) begin
          if (marker_match_pos == yenc_pkg::BEGIN_LEN - 3'd1) begin
            in_body_next           = 1'b1;
            skip_rest_of_line_next = 1'b1;
            marker_alive_next      = 1'b0;
            marker_match_pos_next  = '0;
          end else begin
            marker_match_pos_next = marker_match_pos + 3'd1;
          end
        end else begin
          skip_rest_of_line_next = 1'b1;
          marker_alive_next      = 1'b0;
          marker_match_pos_next  = '0;
        end
      end
    end else if (skip_rest_of_line) begin
      at_line_start_next = 1'b0;
    end else if (at_line_start) begin
      at_line_start_next = 1'b0;
      if (byte_in == yenc_pkg::CHAR_DOT) begin
        dot_pending_next  = 1'b1;
        marker_alive_next = 1'b0;
      end else if (byte_in == yenc_pkg::CHAR_EQ) begin
        leading_eq_pending_next = 1'b1;
        marker_match_pos_next   = 3'd1;
        marker_alive_next       = 1'b1;
      end else begin
        marker_alive_next = 1'b0;
        e1_valid          = 1'b1;
        e1_byte           = yenc_pkg::plain_decode(byte_in);
      end
    end else if (leading_eq_pending) begin
      leading_eq_pending_next = 1'b0;
      if (byte_in == yenc_pkg::CHAR_Y) begin
        marker_match_pos_next = 3'd2;
      end else begin
        marker_alive_next     = 1'b0;
        marker_match_pos_next = '0;
        e1_valid              = 1'b1;
        e1_byte               = yenc_pkg::escaped_decode(byte_in);
      end
    end else if (marker_alive && (marker_match_pos >= 3'd2)) begin
      if ((marker_match_pos < yenc_pkg::END_LEN) &&
          (byte_in == yenc_pkg::end_char(marker_match_pos))) begin
        if (marker_match_pos == yenc_pkg::END_LEN - 3'd1) begin
          e1_valid               = 1'b1;
          e1_kind                = yenc_pkg::KIND_END;
          in_body_next           = 1'b0;
          skip_rest_of_line_next = 1'b1;
          marker_alive_next      = 1'b0;
          marker_match_pos_next  = '0;
        end else begin
          marker_match_pos_next = marker_match_pos + 3'd1;
        end
      end else begin
        // some other =y line, ignored up to its end
        skip_rest_of_line_next = 1'b1;
        marker_alive_next      = 1'b0;
        marker_match_pos_next  = '0;
      end
    end else begin
      if (dot_pending) begin
        dot_pending_next = 1'b0;
        e0_valid         = 1'b1;
        e0_byte          = yenc_pkg::plain_decode(yenc_pkg::CHAR_DOT);
        dot_consumed     = (byte_in == yenc_pkg::CHAR_DOT);
      end
      if (!dot_consumed) begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
          e1_valid            = 1'b1;
          e1_byte             = yenc_pkg::escaped_decode(byte_in);
        end else if (byte_in == yenc_pkg::CHAR_EQ) begin
          escape_pending_next = 1'b1;
        end else begin
          e1_valid = 1'b1;
          e1_byte  = yenc_pkg::plain_decode(byte_in);
        end
      end
    end
  end

  // pack the results, the later one carries last
  always_comb begin
    push = '0;
    if (e0_valid) begin
      push.first_valid    = fire;
      push.first.out_byte = e0_byte;
      push.first.kind     = yenc_pkg::KIND_DATA;
      push.first.last     = !e1_valid;
      push.second_valid   = fire && e1_valid;
      push.second.out_byte = e1_byte;
      push.second.kind     = e1_kind;
      push.second.last     = 1'b1;
    end else begin
      push.first_valid    = fire && e1_valid;
      push.first.out_byte = e1_byte;
      push.first.kind     = e1_kind;
      push.first.last     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_body            <= 1'b0;
      at_line_start      <= 1'b1;
      escape_pending     <= 1'b0;
      dot_pending        <= 1'b0;
      leading_eq_pending <= 1'b0;
      skip_rest_of_line  <= 1'b0;
      marker_match_pos   <= '0;
      marker_alive       <= 1'b1;
    end else if (fire) begin
      in_body            <= in_body_next;
      at_line_start      <= at_line_start_next;
      escape_pending     <= escape_pending_next;
      dot_pending        <= dot_pending_next;
      leading_eq_pending <= leading_eq_pending_next;
      skip_rest_of_line  <= skip_rest_of_line_next;
      marker_match_pos   <= marker_match_pos_next;
      marker_alive       <= marker_alive_next;
    end
  end

endmodule

### rtl/yenc_out_fifo.sv
module yenc_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  yenc_pkg::push_t     push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output yenc_pkg::result_t   head
);

  yenc_pkg::result_t mem [yenc_pkg::FIFO_DEPTH];

  logic [yenc_pkg::PTR_W-1:0] wr_ptr;
  logic [yenc_pkg::PTR_W-1:0] rd_ptr;
  logic [yenc_pkg::CNT_W-1:0] count;
  logic [yenc_pkg::CNT_W-1:0] count_next;
  logic                       pop;
  logic [yenc_pkg::CNT_W-1:0] n_push;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign head      = mem[rd_ptr];
  // room for the worst case of two results
  assign room      = (count <= yenc_pkg::CNT_W'(yenc_pkg::FIFO_DEPTH - 2));

  assign n_push     = yenc_pkg::CNT_W'(push.first_valid) +
                      yenc_pkg::CNT_W'(push.second_valid);
  assign count_next = count + n_push - yenc_pkg::CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.first_valid) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.second_valid) begin
      mem[wr_ptr + yenc_pkg::PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + yenc_pkg::PTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + yenc_pkg::PTR_W'(1);
      end
      count <= count_next;
    end
  end

endmodule

### rtl/yenc_body_decoder.sv
// yenc body decoder: takes one raw article byte per word on the in_* channel and
// gives decoded bytes on the out_* channel. lines are skipped until one that starts
// with =ybegin; the lines after it are decoded (byte minus 42, or minus 106 after an
// '=' escape, modulo 256), CR and LF are dropped and a leading doubled dot loses one
// dot. a body line starting with =yend gives one word with kind set and out_byte zero
// and returns the block to scanning. other =y lines in the body are ignored. each
// input byte gives zero, one or two output words; last marks the final word of a byte.
// timing: one input byte per cycle while the result queue has room. an accepted byte is held
// in the input register, decoded from there, and its words are written into the result queue
// and offered from it (input register, then the result queue).
// a byte enters the decode stage only while the four-entry result queue has room for
// two words, so the output side drains at one word per cycle while out_ready is high and long back-pressure
// fills the queue and then stalls input.
module yenc_body_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       kind,
  output logic       last
);

  // input register
  logic       hold_valid;
  logic [7:0] hold_byte;

  // decode stage control
  logic              room;
  logic              fire;
  yenc_pkg::push_t   push;
  yenc_pkg::result_t head;

  // the held byte is decoded when the queue can take its results
  assign fire     = hold_valid && room;
  assign in_ready = !hold_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= in_byte;
    end
  end

  yenc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .byte_in (hold_byte),
    .push    (push)
  );

  yenc_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_byte = head.out_byte;
  assign kind     = head.kind;
  assign last     = head.last;

endmodule

### rtl/yenc_checker.sv
`include "assert_macros.svh"

module yenc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       kind,
  input logic       last
);

  // a stalled word stays offered
  `YBD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "output word withdrawn")
  // a stalled word keeps its payload
  `YBD_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable({out_byte, kind, last}), "stalled word changed")
  // end of part carries a zero byte
  `YBD_ASSERT(a_end_zero, out_valid && (kind == yenc_pkg::KIND_END) |-> (out_byte == 8'h00), "end of part with non-zero byte")
  // end of part is always the final word of its input byte
  `YBD_ASSERT(a_end_last, out_valid && (kind == yenc_pkg::KIND_END) |-> last, "end of part not marked last")
  // empty and ready straight after a reset cycle
  `YBD_ASSERT_NR(a_reset_empty, rst |=> in_ready && !out_valid, "block not empty after reset")

endmodule

bind yenc_body_decoder yenc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .kind      (kind),
  .last      (last)
);

### test/yenc_body_decoder_tb.sv
`timescale 1ns / 100ps

// self-checking bench for yenc_body_decoder: builds raw article byte streams (well formed
// yenc parts with random content plus noise and broken markers), keeps its own model of
// the decoder state to work out the expected output words, and compares every word
// leaving the block against the oldest expectation
module yenc_body_decoder_tb;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 12;
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, fills the result queue
  localparam int DRAIN_CYCLES = 16;    // idle time after the last owed word
  localparam int PHASE_BYTES  = 350;   // random article bytes per phase (at least)
  localparam int LIMIT_CYCLES = 500000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       kind;
  logic       last;

  yenc_body_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .kind      (kind),
    .last      (last)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // article bytes waiting to be offered, and decoded words still owed by the block
  logic [7:0]        article_q[$];
  yenc_pkg::result_t words_due[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  logic hold_start  = 1'b0;
  logic hold_output = 1'b0;

  int mismatches   = 0;
  int bytes_sent   = 0;
  int data_words   = 0;
  int end_words    = 0;
  int queued_bytes = 0;

  // decoder state as the bench sees it
  logic       in_body;
  logic       at_line_start;
  logic       esc_pending;
  logic       dot_pending;
  logic       eq_pending;
  logic       skip_line;
  logic [2:0] match_pos;
  logic       marker_alive;

  string begin_tag = "=ybegin";
  string end_tag   = "=yend";

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  function automatic yenc_pkg::result_t data_word(input logic [7:0] value);
    yenc_pkg::result_t w;
    w.out_byte = value;
    w.kind     = yenc_pkg::KIND_DATA;
    w.last     = 1'b0;
    return w;
  endfunction

  task automatic clear_decoder_state();
    in_body       = 1'b0;
    at_line_start = 1'b1;
    esc_pending   = 1'b0;
    dot_pending   = 1'b0;
    eq_pending    = 1'b0;
    skip_line     = 1'b0;
    match_pos     = 3'd0;
    marker_alive  = 1'b1;
  endtask

  // works out the words that one accepted article byte gives and queues them
  task automatic predict_article_byte(input logic [7:0] b);
    yenc_pkg::result_t fresh[$];
    yenc_pkg::result_t w;
    logic              swallow;
    swallow = 1'b0;
    if (b == yenc_pkg::CHAR_CR) return;   // carriage returns leave everything untouched
    if (b == yenc_pkg::CHAR_LF) begin
      // a lone leading dot still counts as data at end of line
      if (in_body && dot_pending)
        fresh = {fresh, data_word(yenc_pkg::CHAR_DOT - yenc_pkg::DATA_OFFSET)};
      at_line_start = 1'b1;
      esc_pending   = 1'b0;
      dot_pending   = 1'b0;
      eq_pending    = 1'b0;
      skip_line     = 1'b0;
      match_pos     = 3'd0;
      marker_alive  = 1'b1;
    end else if (!in_body) begin
      // scanning: only a line opening with =ybegin matters
      at_line_start = 1'b0;
      if (!skip_line) begin
        if (marker_alive && match_pos < yenc_pkg::BEGIN_LEN &&
            b == begin_tag[match_pos]) begin
          match_pos++;
          if (match_pos == yenc_pkg::BEGIN_LEN) begin
            in_body      = 1'b1;
            skip_line    = 1'b1;
            marker_alive = 1'b0;
            match_pos    = 3'd0;
          end
        end else begin
          skip_line    = 1'b1;
          marker_alive = 1'b0;
          match_pos    = 3'd0;
        end
      end
    end else if (skip_line) begin
      at_line_start = 1'b0;
    end else if (at_line_start) begin
      at_line_start = 1'b0;
      if (b == yenc_pkg::CHAR_DOT) begin
        dot_pending  = 1'b1;
        marker_alive = 1'b0;
      end else if (b == yenc_pkg::CHAR_EQ) begin
        eq_pending   = 1'b1;
        match_pos    = 3'd1;
        marker_alive = 1'b1;
      end else begin
        marker_alive = 1'b0;
        fresh = {fresh, data_word(b - yenc_pkg::DATA_OFFSET)};
      end
    end else if (eq_pending) begin
      // leading '=' is either the start of a =y line or an ordinary escape
      eq_pending = 1'b0;
      if (b == yenc_pkg::CHAR_Y) begin
        match_pos = 3'd2;
      end else begin
        marker_alive = 1'b0;
        match_pos    = 3'd0;
        fresh = {fresh, data_word(b - yenc_pkg::ESCAPE_OFFSET - yenc_pkg::DATA_OFFSET)};
      end
    end else if (marker_alive && match_pos >= 3'd2) begin
      // =y line: =yend closes the part, anything else is skipped
      if (match_pos < yenc_pkg::END_LEN && b == end_tag[match_pos]) begin
        match_pos++;
        if (match_pos == yenc_pkg::END_LEN) begin
          w.out_byte = 8'h00;
          w.kind     = yenc_pkg::KIND_END;
          w.last     = 1'b0;
          fresh = {fresh, w};
          in_body      = 1'b0;
          skip_line    = 1'b1;
          marker_alive = 1'b0;
          match_pos    = 3'd0;
        end
      end else begin
        skip_line    = 1'b1;
        marker_alive = 1'b0;
        match_pos    = 3'd0;
      end
    end else begin
      if (dot_pending) begin
        dot_pending = 1'b0;
        fresh = {fresh, data_word(yenc_pkg::CHAR_DOT - yenc_pkg::DATA_OFFSET)};
        swallow = (b == yenc_pkg::CHAR_DOT);   // doubled dot loses one
      end
      if (!swallow) begin
        if (esc_pending) begin
          esc_pending = 1'b0;
          fresh = {fresh, data_word(b - yenc_pkg::ESCAPE_OFFSET - yenc_pkg::DATA_OFFSET)};
        end else if (b == yenc_pkg::CHAR_EQ) begin
          esc_pending = 1'b1;
        end else begin
          fresh = {fresh, data_word(b - yenc_pkg::DATA_OFFSET)};
        end
      end
    end
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
    foreach (fresh[i]) words_due = {words_due, fresh[i]};
  endtask

  // ---------------------------------------------------------------- article generation

  task automatic push_byte(input logic [7:0] b);
    article_q = {article_q, b};
    queued_bytes++;
  endtask

  task automatic push_text(input string s);
    foreach (s[i]) push_byte(s[i]);
  endtask

  // mostly CR LF, sometimes bare LF or a doubled CR
  task automatic push_eol();
    case ($urandom_range(3))
      0: push_byte(yenc_pkg::CHAR_LF);
      3: begin
        push_byte(yenc_pkg::CHAR_CR);
        push_byte(yenc_pkg::CHAR_CR);
        push_byte(yenc_pkg::CHAR_LF);
      end
      default: begin
        push_byte(yenc_pkg::CHAR_CR);
        push_byte(yenc_pkg::CHAR_LF);
      end
    endcase
  endtask

  // one data byte yenc encoded, critical characters escaped, others now and then
  task automatic push_encoded(input logic [7:0] d);
    logic [7:0] e;
    e = d + yenc_pkg::DATA_OFFSET;
    if (e == 8'h00 || e == yenc_pkg::CHAR_LF || e == yenc_pkg::CHAR_CR ||
        e == yenc_pkg::CHAR_EQ || $urandom_range(19) == 0) begin
      push_byte(yenc_pkg::CHAR_EQ);
      push_byte(e + yenc_pkg::ESCAPE_OFFSET);
    end else begin
      push_byte(e);
    end
  endtask

  task automatic push_body_line();
    int len;
    len = ($urandom_range(7) == 0) ? $urandom_range(64) : $urandom_range(12);
    // unusual line openings
    case ($urandom_range(11))
      0: push_byte(yenc_pkg::CHAR_DOT);
      1: begin
        push_byte(yenc_pkg::CHAR_DOT);
        push_byte(yenc_pkg::CHAR_DOT);
      end
      2: begin
        push_byte(yenc_pkg::CHAR_EQ);
        push_byte(8'($urandom_range(255)));
      end
      3: begin
        push_byte(yenc_pkg::CHAR_EQ);
        push_byte(yenc_pkg::CHAR_Y);
        push_byte(8'($urandom_range(255)));
      end
      default: ;
    endcase
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(4) == 0) push_byte(8'($urandom_range(255)));
      else push_encoded(8'($urandom_range(255)));
    end
    if ($urandom_range(9) == 0) push_byte(yenc_pkg::CHAR_EQ);   // dangling escape at line end
    push_eol();
  endtask

  // text between parts, sometimes almost a marker
  task automatic push_idle_line();
    case ($urandom_range(5))
      0: push_text("=ybeg");
      1: push_text("=ybegix data");
      2: push_text(" =ybegin not at start");
      3: push_text("=yend outside a part");
      default: begin
        for (int i = $urandom_range(20); i > 0; i--) push_byte(8'($urandom_range(32, 126)));
      end
    endcase
    push_eol();
  endtask

  // one part: header, optional =ypart, body lines, trailer; now and then cut short
  task automatic push_part();
    for (int i = $urandom_range(2); i > 0; i--) push_idle_line();
    push_text("=ybegin");
    if ($urandom_range(3) != 0)
      push_text($sformatf(" line=128 size=%0d name=f%0d.bin", $urandom_range(9999),
                          $urandom_range(99)));
    push_eol();
    if ($urandom_range(2) == 0) begin
      push_text($sformatf("=ypart begin=1 end=%0d", $urandom_range(999)));
      push_eol();
    end
    for (int i = $urandom_range(1, 5); i > 0; i--) begin
      case ($urandom_range(15))
        0: push_text("=ybegin nested");
        1: push_text("=yen");
        2: push_text("=yendx");
        default: ;
      endcase
      push_body_line();
    end
    if ($urandom_range(9) != 0) begin
      push_text("=yend");
      if ($urandom_range(3) != 0) push_text($sformatf(" size=%0d", $urandom_range(9999)));
      push_eol();
    end
  endtask

  task automatic push_noise();
    for (int i = $urandom_range(1, 20); i > 0; i--) push_byte(8'($urandom_range(255)));
  endtask

  task automatic push_random_article(input int count);
    int stop_at;
    stop_at = queued_bytes + count;
    while (queued_bytes < stop_at) begin
      if ($urandom_range(9) < 8) push_part();
      else push_noise();
    end
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_article_byte(in_byte);
        bytes_sent++;
      end
      // a new word may be offered once the current one is taken
      if (!in_valid || in_ready) begin
        if (article_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_byte  <= article_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    yenc_pkg::result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (kind == yenc_pkg::KIND_END) end_words++;
        else data_words++;
        if (words_due.size() == 0) begin
          report_mismatch($sformatf("word with nothing expected: %02h kind %0b last %0b",
                                    out_byte, kind, last));
        end else begin
          want = words_due.pop_front();
          if (out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.out_byte));
          if (kind !== want.kind)
            report_mismatch($sformatf("kind %0b, expected %0b", kind, want.kind));
          if (last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
        end
      end
      out_ready <= !hold_output && ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver hold-off, counted here while the sender keeps offering words
  initial begin
    wait (hold_start);
    @(posedge clk);
    hold_output <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_output <= 1'b0;
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    int send_mix[4];
    int stall_mix[4];
    send_mix  = '{0, 81, 0, 15};
    stall_mix = '{0, 0, 81, 15};
    clear_decoder_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: header, leading dot then data, escape of ff, plain 00, escape cut by
    // end of line, lone dot line, doubled dot line, leading '=' escape, trailer
    push_text("=ybegin");
    push_byte(yenc_pkg::CHAR_LF);
    push_byte(yenc_pkg::CHAR_DOT);
    push_byte(yenc_pkg::CHAR_CR);
    push_byte(8'h41);
    push_byte(yenc_pkg::CHAR_EQ);
    push_byte(8'hff);
    push_byte(8'h00);
    push_byte(yenc_pkg::CHAR_EQ);
    push_byte(yenc_pkg::CHAR_LF);
    push_byte(yenc_pkg::CHAR_DOT);
    push_byte(yenc_pkg::CHAR_LF);
    push_byte(yenc_pkg::CHAR_DOT);
    push_byte(yenc_pkg::CHAR_DOT);
    push_byte(yenc_pkg::CHAR_LF);
    push_byte(yenc_pkg::CHAR_EQ);
    push_byte(8'h00);
    push_byte(yenc_pkg::CHAR_LF);
    push_text("=yend");
    push_byte(yenc_pkg::CHAR_LF);

    // random phases; between phases the sender waits for every owed word
    for (int p = 0; p < 4; p++) begin
      while (article_q.size() != 0 || in_valid || words_due.size() != 0) @(negedge clk);
      send_idle_pct = send_mix[p];
      stall_pct     = stall_mix[p];
      if (p == 0) hold_start = 1'b1;
      push_random_article(PHASE_BYTES);
    end

    while (article_q.size() != 0 || in_valid || words_due.size() != 0) @(negedge clk);
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d article bytes giving %0d data words and %0d end-of-part words,",
             bytes_sent, data_words, end_words);
    $display("under free flow, sparse input, heavy back-pressure and a mixed pattern");
    if (mismatches == 0) begin
      $display("yenc_body_decoder test passed");
    end else begin
      $display("yenc_body_decoder test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(64'd2 * HALF_PERIOD * LIMIT_CYCLES);
    $display("timed out with %0d words still owed", words_due.size());
    $display("yenc_body_decoder test failed");
    $finish;
  end

endmodule
